@@ hdl/wpe_pkg.sv @@
// ----------------------------------------------------------------------------
// wpe_pkg
// Shared types, constants and helpers for the LED serial pulse encoder.
// ----------------------------------------------------------------------------
package wpe_pkg;

	localparam int COLOR_W            = 24;
	localparam int BITS_PER_PIXEL_DEF = 24;
	localparam int TICK_W             = 8;
	localparam int CFG_IDX_W          = 2;
	localparam int S_TDATA_W          = 24;
	localparam int M_TDATA_W          = 8;

	localparam logic [TICK_W-1:0] ONE_HIGH_RST  = 8'd5;
	localparam logic [TICK_W-1:0] ONE_LOW_RST   = 8'd1;
	localparam logic [TICK_W-1:0] ZERO_HIGH_RST = 8'd1;
	localparam logic [TICK_W-1:0] ZERO_LOW_RST  = 8'd5;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_TICK = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HIGH = 2'd1,
		PH_LOW  = 2'd2
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ONE_HIGH  = 2'd0,
		REG_ONE_LOW   = 2'd1,
		REG_ZERO_HIGH = 2'd2,
		REG_ZERO_LOW  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		action_t            action;
		logic [COLOR_W-1:0] color;
		logic               last_pixel;
	} item_t;

	typedef struct packed {
		logic [TICK_W-1:0] one_high;
		logic [TICK_W-1:0] one_low;
		logic [TICK_W-1:0] zero_high;
		logic [TICK_W-1:0] zero_low;
	} timing_t;

	// a programmed length of zero counts as one tick
	function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
		return (v == '0) ? TICK_W'(1) : v;
	endfunction

	function automatic logic [TICK_W-1:0] high_len(input timing_t t, input logic b);
		return at_least_one(b ? t.one_high : t.zero_high);
	endfunction

	function automatic logic [TICK_W-1:0] low_len(input timing_t t, input logic b);
		return at_least_one(b ? t.one_low : t.zero_low);
	endfunction

endpackage

@@ hdl/wpe_front.sv @@
// ----------------------------------------------------------------------------
// wpe_front
// Input stage: takes stream words, classifies them and registers them.
// ----------------------------------------------------------------------------
module wpe_front
	import wpe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [23:0] color
	input  logic                 s_tuser,   // action
	input  logic                 s_tlast,   // last_pixel
	output logic                 item_valid,
	output item_t                item,
	input  logic                 q_full
);

	logic  valid_s1;
	item_t item_s1;
	logic  move;

	assign move     = valid_s1 && !q_full;
	assign s_tready = !valid_s1 || !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.action     <= s_tuser ? ACT_TICK : ACT_LOAD;
			item_s1.color      <= s_tdata[COLOR_W-1:0];
			item_s1.last_pixel <= s_tlast;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

@@ hdl/wpe_queue.sv @@
// ----------------------------------------------------------------------------
// wpe_queue
// Two-entry queue between the input stage and the waveform engine.
// ----------------------------------------------------------------------------
module wpe_queue
	import wpe_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_valid,
	input  item_t wr_item,
	output logic  full,
	output logic  rd_valid,
	output item_t rd_item,
	input  logic  rd_pop
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign full     = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign push     = wr_valid && !full;
	assign pop      = rd_pop && rd_valid;
	assign rd_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

@@ hdl/wpe_back.sv @@
// ----------------------------------------------------------------------------
// wpe_back
// Waveform engine: holding slot, bit shifter, phase counter, output register.
// ----------------------------------------------------------------------------
module wpe_back
	import wpe_pkg::*;
#(
	parameter int BITS_PER_PIXEL = BITS_PER_PIXEL_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data,
	input  logic                 q_valid,
	input  item_t                q_item,
	output logic                 q_pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata    // [0] line [1] accepted [2] busy_res [3] frame_done
);

	localparam int IDX_W = $clog2(BITS_PER_PIXEL);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BITS_PER_PIXEL - 1);

	timing_t            timing_q;
	logic [COLOR_W-1:0] shift_q, n_shift;
	logic [IDX_W-1:0]   idx_q, n_idx;
	phase_t             phase_q, n_phase;
	logic [TICK_W-1:0]  cnt_q, n_cnt;
	logic [COLOR_W-1:0] held_q, n_held;
	logic               held_valid_q, n_held_valid;
	logic               held_last_q, n_held_last;
	logic               cur_last_q, n_cur_last;
	logic               line_q, n_line;
	logic               acc, done;
	logic               fire;
	logic               m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	assign cfg_ready = 1'b1;
	assign fire      = q_valid && (!m_tvalid_q || m_tready);
	assign q_pop     = fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.one_high  <= ONE_HIGH_RST;
			timing_q.one_low   <= ONE_LOW_RST;
			timing_q.zero_high <= ZERO_HIGH_RST;
			timing_q.zero_low  <= ZERO_LOW_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ONE_HIGH:  timing_q.one_high  <= cfg_data;
				REG_ONE_LOW:   timing_q.one_low   <= cfg_data;
				REG_ZERO_HIGH: timing_q.zero_high <= cfg_data;
				REG_ZERO_LOW:  timing_q.zero_low  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		n_shift      = shift_q;
		n_idx        = idx_q;
		n_phase      = phase_q;
		n_cnt        = cnt_q;
		n_held       = held_q;
		n_held_valid = held_valid_q;
		n_held_last  = held_last_q;
		n_cur_last   = cur_last_q;
		n_line       = line_q;
		acc          = 1'b0;
		done         = 1'b0;
		if (q_item.action == ACT_LOAD) begin
			if (!held_valid_q) begin
				n_held       = q_item.color;
				n_held_last  = q_item.last_pixel;
				n_held_valid = 1'b1;
				acc          = 1'b1;
			end
		end else begin
			// idle line picks up a waiting pixel on the same tick
			if (n_phase == PH_IDLE && n_held_valid) begin
				n_shift      = held_q;
				n_cur_last   = held_last_q;
				n_held_valid = 1'b0;
				n_idx        = '0;
				n_phase      = PH_HIGH;
				n_cnt        = high_len(timing_q, held_q[0]);
			end
			if (n_phase == PH_IDLE) begin
				n_line = 1'b0;
			end else begin
				n_line = (n_phase == PH_HIGH);
				n_cnt  = n_cnt - TICK_W'(1);
				if (n_cnt == '0) begin
					if (n_phase == PH_HIGH) begin
						n_phase = PH_LOW;
						n_cnt   = low_len(timing_q, n_shift[0]);
					end else if (n_idx >= LAST_IDX) begin
						done       = n_cur_last;
						n_cur_last = 1'b0;
						n_shift    = '0;
						n_idx      = '0;
						if (n_held_valid) begin
							n_shift      = held_q;
							n_cur_last   = held_last_q;
							n_held_valid = 1'b0;
							n_phase      = PH_HIGH;
							n_cnt        = high_len(timing_q, held_q[0]);
						end else begin
							n_phase = PH_IDLE;
							n_cnt   = '0;
						end
					end else begin
						n_shift = {1'b0, n_shift[COLOR_W-1:1]};
						n_idx   = n_idx + IDX_W'(1);
						n_phase = PH_HIGH;
						n_cnt   = high_len(timing_q, n_shift[0]);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q      <= '0;
			idx_q        <= '0;
			phase_q      <= PH_IDLE;
			cnt_q        <= '0;
			held_valid_q <= 1'b0;
			held_last_q  <= 1'b0;
			cur_last_q   <= 1'b0;
			line_q       <= 1'b0;
		end else if (fire) begin
			shift_q      <= n_shift;
			idx_q        <= n_idx;
			phase_q      <= n_phase;
			cnt_q        <= n_cnt;
			held_valid_q <= n_held_valid;
			held_last_q  <= n_held_last;
			cur_last_q   <= n_cur_last;
			line_q       <= n_line;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			held_q <= n_held;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_tdata_q <= {(M_TDATA_W-4)'(0), done, (n_phase != PH_IDLE), acc, n_line};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_idle_cnt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (cnt_q == '0))
		else $error("idle phase with nonzero count");

	a_active_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (cnt_q != '0))
		else $error("active phase with zero count");

	a_load_fills_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && q_item.action == ACT_LOAD && !held_valid_q) |=> held_valid_q)
		else $error("accepted load did not fill slot");

	a_acc_done_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> !(m_tdata_q[1] && m_tdata_q[3]))
		else $error("accepted and frame_done in one word");

endmodule

@@ hdl/ws2812_pulse_encoder.sv @@
// Path: input stage register, two-entry queue, then output register, in that order.
// Throughput: one word per cycle while the output accepts; these registers absorb
// short stalls on either side, and a long output stall backs up to s_tready.
// The waveform engine handles one tick per clock when a word is queued and the output is not stalled.
// Reset (arst_n low) clears control state, line low, timing registers to 5/1/1/5.
// ----------------------------------------------------------------------------
// ws2812_pulse_encoder
// Serial LED colour encoder: pixel loads and ticks in, line level out.
// ----------------------------------------------------------------------------
module ws2812_pulse_encoder
	import wpe_pkg::*;
#(
	parameter int BITS_PER_PIXEL = BITS_PER_PIXEL_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [23:0] color
	input  logic                 s_tuser,   // action
	input  logic                 s_tlast,   // last_pixel
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata    // [0] line [1] accepted [2] busy_res [3] frame_done
);

	logic  f_valid;
	item_t f_item;
	logic  q_full;
	logic  q_valid;
	item_t q_item;
	logic  q_pop;

	wpe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.item_valid (f_valid),
		.item       (f_item),
		.q_full     (q_full)
	);

	wpe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_item  (f_item),
		.full     (q_full),
		.rd_valid (q_valid),
		.rd_item  (q_item),
		.rd_pop   (q_pop)
	);

	wpe_back #(
		.BITS_PER_PIXEL (BITS_PER_PIXEL)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

@@ bench/ws2812_pulse_encoder_test.sv @@
// ----------------------------------------------------------------------------
// ws2812_pulse_encoder_test
// Self-checking bench for the LED pulse encoder. Pixel loads and ticks are
// streamed in with random gaps while the output side stalls at random and
// once for a long stretch. Every result word is compared field by field with
// hand-written levels for the directed rows, else with a cycle-free model of
// the waveform engine that runs when the words are queued. Timing registers are
// changed between phases while the engine is drained, with extreme and zero phase lengths among the settings.
// ----------------------------------------------------------------------------
module ws2812_pulse_encoder_test;
	import wpe_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT     = 400000;
	localparam int CALM_LO   = 1500;
	localparam int CALM_HI   = 2600;
	localparam int HOLD_AT   = 150;
	localparam int HOLD_LEN  = 400;
	localparam int PIX_BITS  = BITS_PER_PIXEL_DEF;

	typedef struct packed {
		logic frame_done;
		logic busy;
		logic accepted;
		logic line;
	} level_t;

	typedef struct {
		item_t  it;
		bit     typed;
		level_t lv;
	} row_t;

	typedef struct {
		cfg_reg_t          idx;
		logic [TICK_W-1:0] data;
	} cfg_wr_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TICK_W-1:0]    cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	ws2812_pulse_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [23:0] color
		.s_tuser   (s_tuser),   // action
		.s_tlast   (s_tlast),   // last_pixel
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)    // [0] line [1] accepted [2] busy_res [3] frame_done
	);

	always #5 clk = ~clk;

	item_t   items_to_send[$];
	level_t  levels_due[$];
	cfg_wr_t timing_writes[$];
	row_t    rows[$];

	int cyc = 0;
	int errors = 0;
	int rx_count = 0;
	int hold_left = 0;
	bit held_once = 1'b0;

	// waveform engine model state
	timing_t           m_tm;
	logic [COLOR_W-1:0] m_shift;
	logic [4:0]        m_bit;
	phase_t            m_phase;
	logic [TICK_W-1:0] m_count;
	logic [COLOR_W-1:0] m_held_color;
	logic              m_held_valid;
	logic              m_held_last;
	logic              m_cur_last;
	logic              m_line;

	function automatic bit take_break();
		if (cyc >= CALM_LO && cyc < CALM_HI)
			return 1'b0;
		return $urandom_range(99) < 32;
	endfunction

	// phase length for the bit now at the bottom of the shift word
	function automatic logic [TICK_W-1:0] ticks_for(input bit high);
		logic [TICK_W-1:0] v;
		if (m_shift[0])
			v = high ? m_tm.one_high : m_tm.one_low;
		else
			v = high ? m_tm.zero_high : m_tm.zero_low;
		return (v == '0) ? 8'd1 : v;
	endfunction

	function automatic void start_pixel();
		m_shift      = m_held_color;
		m_cur_last   = m_held_last;
		m_held_valid = 1'b0;
		m_bit        = '0;
		m_phase      = PH_HIGH;
		m_count      = ticks_for(1'b1);
	endfunction

	function automatic level_t next_levels(input item_t it);
		level_t r;
		r = '0;
		if (it.action == ACT_LOAD) begin
			if (!m_held_valid) begin
				m_held_color = it.color;
				m_held_last  = it.last_pixel;
				m_held_valid = 1'b1;
				r.accepted   = 1'b1;
			end
		end else begin
			if (m_phase == PH_IDLE && m_held_valid)
				start_pixel();
			if (m_phase == PH_IDLE) begin
				m_line = 1'b0;
			end else begin
				m_line  = (m_phase == PH_HIGH);
				m_count = m_count - 8'd1;
				if (m_count == '0) begin
					if (m_phase == PH_HIGH) begin
						m_phase = PH_LOW;
						m_count = ticks_for(1'b0);
					end else if (int'(m_bit) >= PIX_BITS - 1) begin
						r.frame_done = m_cur_last;
						m_cur_last   = 1'b0;
						m_shift      = '0;
						m_bit        = '0;
						if (m_held_valid) begin
							start_pixel();
						end else begin
							m_phase = PH_IDLE;
							m_count = '0;
						end
					end else begin
						m_shift = m_shift >> 1;
						m_bit   = m_bit + 5'd1;
						m_phase = PH_HIGH;
						m_count = ticks_for(1'b1);
					end
				end
			end
		end
		r.line = m_line;
		r.busy = (m_phase != PH_IDLE);
		return r;
	endfunction

	function automatic item_t make_item(input action_t a, input logic [COLOR_W-1:0] c,
			input logic l);
		item_t it;
		it.action     = a;
		it.color      = c;
		it.last_pixel = l;
		return it;
	endfunction

	task automatic queue_word(input item_t it);
		items_to_send.push_back(it);
		levels_due.push_back(next_levels(it));
	endtask

	task automatic queue_tick();
		logic [COLOR_W-1:0] c;
		c = COLOR_W'($urandom);
		queue_word(make_item(ACT_TICK, c, 1'($urandom_range(1))));
	endtask

	task automatic add_row(input action_t a, input logic [COLOR_W-1:0] c, input logic l,
			input bit typed, input logic ln, input logic acc, input logic bsy,
			input logic dn);
		row_t r;
		r.it    = make_item(a, c, l);
		r.typed = typed;
		r.lv    = '{frame_done: dn, busy: bsy, accepted: acc, line: ln};
		rows.push_back(r);
	endtask

	// tick until the engine has shifted out everything it holds
	task automatic drain_line();
		while (m_phase != PH_IDLE || m_held_valid)
			queue_tick();
	endtask

	task automatic settle();
		while (levels_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_timing(input logic [TICK_W-1:0] oh, input logic [TICK_W-1:0] ol,
			input logic [TICK_W-1:0] zh, input logic [TICK_W-1:0] zl);
		settle();
		timing_writes.push_back('{REG_ONE_HIGH, oh});
		timing_writes.push_back('{REG_ONE_LOW, ol});
		timing_writes.push_back('{REG_ZERO_HIGH, zh});
		timing_writes.push_back('{REG_ZERO_LOW, zl});
		m_tm.one_high  = oh;
		m_tm.one_low   = ol;
		m_tm.zero_high = zh;
		m_tm.zero_low  = zl;
		while (timing_writes.size() != 0 || cfg_valid)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// mostly well-formed pixel loads into an empty slot, ticks in between,
	// and now and then a load into a full slot
	task automatic random_run(input int n);
		logic [COLOR_W-1:0] c;
		for (int i = 0; i < n; i++) begin
			c = COLOR_W'($urandom);
			if (!m_held_valid && $urandom_range(99) < 30)
				queue_word(make_item(ACT_LOAD, c, $urandom_range(2) == 0));
			else if ($urandom_range(99) < 4)
				queue_word(make_item(ACT_LOAD, c, 1'($urandom_range(1))));
			else
				queue_tick();
		end
		drain_line();
	endtask

	task automatic check_field(input string name, input logic want, input logic got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin : tx
		item_t it;
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (items_to_send.size() != 0 && !take_break()) begin
				it = items_to_send.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= it.color;
				s_tuser  <= it.action;
				s_tlast  <= it.last_pixel;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : cfg_drv
		cfg_wr_t w;
		if (arst_n && (!cfg_valid || cfg_ready)) begin
			if (timing_writes.size() != 0 && !take_break()) begin
				w = timing_writes.pop_front();
				cfg_valid <= 1'b1;
				cfg_index <= w.idx;
				cfg_data  <= w.data;
			end else begin
				cfg_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : rx
		level_t want;
		if (m_tvalid && m_tready) begin
			if (levels_due.size() == 0) begin
				errors++;
				$display("%0t: word with nothing pending, expected none actual %h",
					$time, m_tdata);
			end else begin
				want = levels_due.pop_front();
				check_field("line", want.line, m_tdata[0]);
				check_field("accepted", want.accepted, m_tdata[1]);
				check_field("busy_res", want.busy, m_tdata[2]);
				check_field("frame_done", want.frame_done, m_tdata[3]);
			end
			rx_count++;
		end
		// one long hold-off so the block backs up into its input
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (rx_count >= HOLD_AT && !held_once) begin
			held_once = 1'b1;
			hold_left = HOLD_LEN;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !take_break();
		end
	end

	initial begin
		m_tm         = '{one_high: ONE_HIGH_RST, one_low: ONE_LOW_RST,
			zero_high: ZERO_HIGH_RST, zero_low: ZERO_LOW_RST};
		m_shift      = '0;
		m_bit        = '0;
		m_phase      = PH_IDLE;
		m_count      = '0;
		m_held_color = '0;
		m_held_valid = 1'b0;
		m_held_last  = 1'b0;
		m_cur_last   = 1'b0;
		m_line       = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part at reset timing (5/1/1/5)
		// idle, nothing held
		add_row(ACT_TICK, 24'h000000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
		add_row(ACT_LOAD, 24'hFFFFFF, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
		// slot full, refused
		add_row(ACT_LOAD, 24'h000000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
		// idle tick takes held pixel
		add_row(ACT_TICK, 24'hFFFFFF, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
		// line keeps its level
		add_row(ACT_LOAD, 24'h000000, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
		add_row(ACT_LOAD, 24'hABCDEF, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
		for (int i = 0; i < 10; i++)
			add_row(ACT_TICK, 24'h5A5A5A, i[0], 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		foreach (rows[i]) begin
			items_to_send.push_back(rows[i].it);
			if (rows[i].typed) begin
				void'(next_levels(rows[i].it));
				levels_due.push_back(rows[i].lv);
			end else begin
				levels_due.push_back(next_levels(rows[i].it));
			end
		end
		drain_line();

		// zero lengths act as one tick
		set_timing(8'd0, 8'd0, 8'd0, 8'd0);
		random_run(60);

		// long one-high, held pixel follows at once
		set_timing(8'd255, 8'd0, 8'd1, 8'd1);
		queue_word(make_item(ACT_LOAD, 24'h000001, 1'b0));
		queue_tick();
		queue_word(make_item(ACT_LOAD, 24'h000000, 1'b1));
		drain_line();

		// long zero-high
		set_timing(8'd1, 8'd1, 8'd255, 8'd0);
		queue_word(make_item(ACT_LOAD, 24'hFFFFFE, 1'b1));
		drain_line();

		for (int k = 0; k < 2; k++) begin
			set_timing(8'($urandom_range(4)), 8'($urandom_range(4)),
				8'($urandom_range(4)), 8'($urandom_range(4)));
			random_run(30);
		end

		settle();
		repeat (20) @(negedge clk);
		if (levels_due.size() != 0) begin
			errors++;
			$display("%0t: %0d words never arrived, expected 0 actual %0d", $time,
				levels_due.size(), levels_due.size());
		end
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/wpe_pkg.sv
hdl/wpe_front.sv
hdl/wpe_queue.sv
hdl/wpe_back.sv
hdl/ws2812_pulse_encoder.sv
bench/ws2812_pulse_encoder_test.sv
